[rtl/stream_find_replace_defines.svh]
// Assertion macros shared by the stream find-and-replace RTL.
`ifndef STREAM_FIND_REPLACE_DEFINES_SVH
`define STREAM_FIND_REPLACE_DEFINES_SVH

// cond must hold at every clock edge outside reset
`define SFR_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define SFR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define SFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/sfr_pkg.sv]
// Types, register indexes and helpers for the stream find-and-replace block.
`default_nettype none

package sfr_pkg;

  localparam int RegBytes       = 16;
  localparam int LenW           = 5;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 64;
  localparam int MaxReplacement = 16;

  typedef logic [7:0]          byte_t;
  typedef logic [LenW-1:0]     len_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  localparam cfg_idx_t RegPatternLow      = 3'd0;
  localparam cfg_idx_t RegPatternHigh     = 3'd1;
  localparam cfg_idx_t RegPatternLength   = 3'd2;
  localparam cfg_idx_t RegReplacementLow  = 3'd3;
  localparam cfg_idx_t RegReplacementHigh = 3'd4;
  localparam cfg_idx_t RegReplacementLen  = 3'd5;

  localparam len_t RlenCap = len_t'((MaxReplacement < RegBytes) ? MaxReplacement : RegBytes);

  function automatic byte_t pick_byte(input cfg_data_t lo, input cfg_data_t hi,
                                      input logic [3:0] i);
    cfg_data_t w;
    w = i[3] ? hi : lo;
    return w[{i[2:0], 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

[rtl/sfr_if.sv]
// Stream interfaces for the input and result channels of the find-and-replace block.
`default_nettype none

interface sfr_in_if;
  logic          valid;
  logic          ready;
  sfr_pkg::byte_t in_byte;
  logic          in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface sfr_out_if;
  logic          valid;
  logic          ready;
  sfr_pkg::byte_t out_byte;
  logic          out_valid;
  logic          out_last;
  logic          out_stream_end;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  output out_stream_end, input ready);
  modport sink   (input valid, input out_byte, input out_valid, input out_last,
                  input out_stream_end, output ready);
endinterface

`default_nettype wire

[rtl/stream_find_replace.sv]
// Streaming find-and-replace: sequencer, pending window and result register.
//
// Usage: program pattern and replacement through the write port (index 0..5)
// while the block is idle, then send bytes on in_i; in_last closes a stream.
// Each input transaction yields zero or more result transactions on out_o;
// out_last marks the final result of a transaction and out_stream_end the
// final result of a stream. A stream end with nothing to emit gives one
// result with out_valid low.
// The block takes one input byte at a time; in_i.ready is high only while
// the sequencer is idle. Once the window is full, pattern bytes are compared
// one at a time on the single byte comparator (none with an empty pattern);
// the emit path sends one byte per cycle (oldest, replacement or flushed
// byte) while it is not stalled. out_o.valid rises only once a result is
// written into the output register.
// Results pass through a one-entry hold stage and an output register; when
// both are full and out_o.ready is low the next emit waits, nothing is lost.
// Reset empties the window and clears the configuration registers to zero;
// the window contents need no clearing.
`default_nettype none

`include "stream_find_replace_defines.svh"

module stream_find_replace #(
  parameter int MAX_PATTERN = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  sfr_pkg::cfg_idx_t   cfg_idx_i,
  input  sfr_pkg::cfg_data_t  cfg_data_i,
  sfr_in_if.sink              in_i,
  sfr_out_if.source           out_o
);

  localparam int WinDepth =
    (MAX_PATTERN < sfr_pkg::RegBytes) ? MAX_PATTERN : sfr_pkg::RegBytes;
  localparam int IdxW     = (WinDepth > 1) ? $clog2(WinDepth) : 1;
  localparam sfr_pkg::len_t PlenCap = sfr_pkg::len_t'(WinDepth);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PFLUSH = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_CMP    = 3'd3;
  localparam logic [2:0] S_MISS   = 3'd4;
  localparam logic [2:0] S_REPL   = 3'd5;
  localparam logic [2:0] S_FLUSH  = 3'd6;
  localparam logic [2:0] S_END    = 3'd7;

  sfr_pkg::cfg_data_t pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
  sfr_pkg::len_t      pat_len_q, rep_len_q;

  logic [2:0]     state_q, state_d;
  sfr_pkg::len_t  count_q, count_d;
  sfr_pkg::len_t  idx_q, idx_d;
  sfr_pkg::byte_t byte_q;
  logic           last_q;
  logic           hold_v_q, hold_v_d;
  sfr_pkg::byte_t hold_byte_q, hold_byte_d;
  logic           out_v_q, out_v_d;
  sfr_pkg::byte_t out_byte_q, out_byte_d;
  logic           out_dv_q, out_dv_d;
  logic           out_last_q, out_last_d;
  logic           out_end_q, out_end_d;

  sfr_pkg::byte_t win_q [WinDepth];

  sfr_pkg::len_t  plen, rlen;
  sfr_pkg::byte_t win_head, win_cmp, pat_byte, rep_byte, em_byte;
  logic           in_fire, slot_free, em_go, em_req, em_fire, end_push, push;
  logic           shift, wr;

  assign plen      = (pat_len_q > PlenCap) ? PlenCap : pat_len_q;
  assign rlen      = (rep_len_q > sfr_pkg::RlenCap) ? sfr_pkg::RlenCap : rep_len_q;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire   = in_i.valid && in_i.ready;
  assign slot_free = !out_v_q || out_o.ready;
  assign em_go     = !hold_v_q || slot_free;
  assign win_head  = win_q[0];
  assign win_cmp   = win_q[idx_q[IdxW-1:0]];
  assign pat_byte  = sfr_pkg::pick_byte(pat_lo_q, pat_hi_q, idx_q[3:0]);
  assign rep_byte  = sfr_pkg::pick_byte(rep_lo_q, rep_hi_q, idx_q[3:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= '0;
      rep_lo_q  <= '0;
      rep_hi_q  <= '0;
      rep_len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfr_pkg::RegPatternLow:      pat_lo_q  <= cfg_data_i;
        sfr_pkg::RegPatternHigh:     pat_hi_q  <= cfg_data_i;
        sfr_pkg::RegPatternLength:   pat_len_q <= cfg_data_i[sfr_pkg::LenW-1:0];
        sfr_pkg::RegReplacementLow:  rep_lo_q  <= cfg_data_i;
        sfr_pkg::RegReplacementHigh: rep_hi_q  <= cfg_data_i;
        sfr_pkg::RegReplacementLen:  rep_len_q <= cfg_data_i[sfr_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    em_req   = 1'b0;
    em_byte  = win_head;
    shift    = 1'b0;
    wr       = 1'b0;
    end_push = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (plen == '0) ? S_PFLUSH : S_DRAIN;
        end
      end
      S_PFLUSH: begin
        em_req = 1'b1;
        if (count_q != '0) begin
          if (em_go) begin
            shift   = 1'b1;
            count_d = count_q - 1'b1;
          end
        end else begin
          em_byte = byte_q;
          if (em_go) begin
            state_d = S_END;
          end
        end
      end
      S_DRAIN: begin
        if (count_q >= plen) begin
          em_req = 1'b1;
          if (em_go) begin
            shift   = 1'b1;
            count_d = count_q - 1'b1;
          end
        end else begin
          wr      = 1'b1;
          count_d = count_q + 1'b1;
          idx_d   = '0;
          state_d = (count_q + 1'b1 == plen) ? S_CMP : S_FLUSH;
        end
      end
      S_CMP: begin
        if (win_cmp != pat_byte) begin
          state_d = S_MISS;
        end else if (idx_q == plen - 1'b1) begin
          idx_d   = '0;
          state_d = S_REPL;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_MISS: begin
        em_req = 1'b1;
        if (em_go) begin
          shift   = 1'b1;
          count_d = count_q - 1'b1;
          state_d = S_FLUSH;
        end
      end
      S_REPL: begin
        if (idx_q < rlen) begin
          em_req  = 1'b1;
          em_byte = rep_byte;
          if (em_go) begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          count_d = '0;
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (last_q && count_q != '0) begin
          em_req = 1'b1;
          if (em_go) begin
            shift   = 1'b1;
            count_d = count_q - 1'b1;
          end
        end else begin
          state_d = S_END;
        end
      end
      S_END: begin
        if (hold_v_q || last_q) begin
          if (slot_free) begin
            end_push = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // one result is held back so the last one of a transaction can be tagged
  always_comb begin
    em_fire     = em_req && em_go;
    push        = (em_fire && hold_v_q) || end_push;
    hold_v_d    = em_fire ? 1'b1 : (end_push ? 1'b0 : hold_v_q);
    hold_byte_d = em_fire ? em_byte : hold_byte_q;
    out_v_d     = push ? 1'b1 : (out_o.ready ? 1'b0 : out_v_q);
    out_byte_d  = out_byte_q;
    out_dv_d    = out_dv_q;
    out_last_d  = out_last_q;
    out_end_d   = out_end_q;
    if (end_push) begin
      out_byte_d = hold_v_q ? hold_byte_q : '0;
      out_dv_d   = hold_v_q;
      out_last_d = 1'b1;
      out_end_d  = last_q;
    end else if (push) begin
      out_byte_d = hold_byte_q;
      out_dv_d   = 1'b1;
      out_last_d = 1'b0;
      out_end_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      last_q   <= 1'b0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
      if (in_fire) begin
        last_q <= in_i.in_last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= in_i.in_byte;
    end
    hold_byte_q <= hold_byte_d;
    out_byte_q  <= out_byte_d;
    out_dv_q    <= out_dv_d;
    out_last_q  <= out_last_d;
    out_end_q   <= out_end_d;
  end

  // oldest byte at entry 0
  always_ff @(posedge clk_i) begin
    if (shift) begin
      for (int k = 0; k < WinDepth - 1; k++) begin
        win_q[k] <= win_q[k+1];
      end
    end else if (wr) begin
      win_q[count_q[IdxW-1:0]] <= byte_q;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.out_byte       = out_byte_q;
  assign out_o.out_valid      = out_dv_q;
  assign out_o.out_last       = out_last_q;
  assign out_o.out_stream_end = out_end_q;

  `SFR_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= PlenCap, "window overfilled")
  `SFR_ASSERT_IMPLY(a_idle_hold_empty, clk_i, rst_ni, state_q == S_IDLE, !hold_v_q,
    "held result left over at idle")
  `SFR_ASSERT_IMPLY(a_cmp_window_full, clk_i, rst_ni, state_q == S_CMP,
    (count_q == plen) && (idx_q < plen), "compare without full window")
  `SFR_ASSERT_NEXT(a_end_push, clk_i, rst_ni, end_push,
    (state_q == S_IDLE) && !hold_v_q && out_v_q && out_last_q, "closing result not posted")

endmodule

`default_nettype wire
